// ===== rtl/core/gcm_gf128_multiply_core_assert.svh =====
// Assertion macros for the GF(2^128) multiply core checker.
// Depends on nothing; included by the checker file.
`ifndef GCM_GF128_MULTIPLY_CORE_ASSERT_SVH
`define GCM_GF128_MULTIPLY_CORE_ASSERT_SVH

// Check a property on every rising clock edge while reset is released.
`define GCMGF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Check a property on every rising clock edge, reset included.
`define GCMGF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/gcmgf_pkg.sv =====
// Shared types and constants for the GF(2^128) multiply core.
// No dependencies; used by every module of the core.
package gcmgf_pkg;

  localparam int unsigned BlockWidth    = 128;
  localparam int unsigned HalfWidth     = 64;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NumStages     = BlockWidth / StepsPerStage;
  localparam int unsigned Latency       = NumStages;

  // Reduction constant R: 0xE1 in byte 0, then zeros.
  localparam logic [BlockWidth-1:0] RedPoly = {8'hE1, {(BlockWidth-8){1'b0}}};

  typedef struct packed {
    logic [HalfWidth-1:0] x_hi;
    logic [HalfWidth-1:0] x_lo;
    logic [HalfWidth-1:0] y_hi;
    logic [HalfWidth-1:0] y_lo;
  } gcmgf_req_t;

  typedef struct packed {
    logic [HalfWidth-1:0] z_hi;
    logic [HalfWidth-1:0] z_lo;
  } gcmgf_rsp_t;

  // Work carried between stages: running multiplicand V, accumulator A,
  // and the multiplier Y with unused bits left-aligned.
  typedef struct packed {
    logic [BlockWidth-1:0] v;
    logic [BlockWidth-1:0] a;
    logic [BlockWidth-1:0] y;
  } gcmgf_pipe_t;

endpackage

// ===== rtl/core/gcmgf_stage.sv =====
// One pipeline stage of the GF(2^128) multiply: eight shift-and-add steps.
// Depends on gcmgf_pkg.
module gcmgf_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  gcmgf_pkg::gcmgf_pipe_t pipe_i,
  output logic                  valid_o,
  output gcmgf_pkg::gcmgf_pipe_t pipe_o
);

  logic                   valid_q;
  gcmgf_pkg::gcmgf_pipe_t pipe_d, pipe_q;

  // Consume the top Y bit per step: add V, then shift V right and reduce.
  always_comb begin
    logic lsb;
    pipe_d = pipe_i;
    for (int unsigned s = 0; s < gcmgf_pkg::StepsPerStage; s++) begin
      if (pipe_d.y[gcmgf_pkg::BlockWidth-1]) begin
        pipe_d.a = pipe_d.a ^ pipe_d.v;
      end
      lsb      = pipe_d.v[0];
      pipe_d.v = pipe_d.v >> 1;
      if (lsb) begin
        pipe_d.v = pipe_d.v ^ gcmgf_pkg::RedPoly;
      end
      pipe_d.y = pipe_d.y << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ===== rtl/core/gcm_gf128_multiply_core.sv =====
// GF(2^128) multiply core as used by GHASH in GCM; top level.
// Depends on gcmgf_pkg and gcmgf_stage.
//
// Usage:
//   Input channel: drive req_i (X and Y, each as high and low 64-bit halves,
//   byte 0 in the top byte of the high half) and raise start_i. A transfer
//   happens at every rising edge with start_i high and busy_o low. busy_o is
//   always low: the pipeline never holds off, so one product can enter per
//   clock cycle without gaps.
//   Result channel: done_o is high for exactly one cycle with the product on
//   rsp_o; that cycle's closing edge is the transfer. The receiver cannot
//   stall, so results must be captured when done_o is seen.
//   Each product passes through the 16-stage chain, each stage running eight
//   of the 128 shift-and-add steps, and leaves it registered.
//   Throughput: one product per cycle.
//   Results leave in input order.
//   Reset: rst_ni low clears all stage valid bits at once; items in flight
//   are dropped and no result follows. Data registers are not reset.
module gcm_gf128_multiply_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  gcmgf_pkg::gcmgf_req_t req_i,
  output logic                  done_o,
  output gcmgf_pkg::gcmgf_rsp_t rsp_o
);

  logic                   valid_w [gcmgf_pkg::NumStages+1];
  gcmgf_pkg::gcmgf_pipe_t pipe_w  [gcmgf_pkg::NumStages+1];

  // Never stall the input side.
  assign busy_o = 1'b0;

  // Load V with X, clear the accumulator, left-align Y (bit 0 at the top).
  assign valid_w[0]  = start_i;
  assign pipe_w[0].v = {req_i.x_hi, req_i.x_lo};
  assign pipe_w[0].a = '0;
  assign pipe_w[0].y = {req_i.y_hi, req_i.y_lo};

  // Advance through the stage chain; valid bits travel with the data.
  for (genvar g = 0; g < gcmgf_pkg::NumStages; g++) begin : g_stage
    gcmgf_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[g]),
      .pipe_i  (pipe_w[g]),
      .valid_o (valid_w[g+1]),
      .pipe_o  (pipe_w[g+1])
    );
  end

  // Present the accumulator of the last stage as the product.
  assign done_o     = valid_w[gcmgf_pkg::NumStages];
  assign rsp_o.z_hi = pipe_w[gcmgf_pkg::NumStages].a[gcmgf_pkg::BlockWidth-1:
                                                     gcmgf_pkg::HalfWidth];
  assign rsp_o.z_lo = pipe_w[gcmgf_pkg::NumStages].a[gcmgf_pkg::HalfWidth-1:0];

endmodule

// ===== rtl/core/gcmgf_checker.sv =====
// Port-level checks for the GF(2^128) multiply core, with its bind.
// Depends on gcmgf_pkg and gcm_gf128_multiply_core_assert.svh.
`include "gcm_gf128_multiply_core_assert.svh"

module gcmgf_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input gcmgf_pkg::gcmgf_req_t req_i,
  input logic                  done_o,
  input gcmgf_pkg::gcmgf_rsp_t rsp_o
);

  localparam logic [gcmgf_pkg::HalfWidth-1:0] OneHi =
    {1'b1, {(gcmgf_pkg::HalfWidth-1){1'b0}}};

  `GCMGF_ASSERT_ALWAYS(a_never_busy, clk_i, !busy_o)

  `GCMGF_ASSERT(a_done_follows_transfer, clk_i, rst_ni,
    done_o |-> $past(start_i && !busy_o, gcmgf_pkg::Latency))

  `GCMGF_ASSERT(a_zero_x_gives_zero, clk_i, rst_ni,
    (done_o && $past(req_i.x_hi == '0 && req_i.x_lo == '0, gcmgf_pkg::Latency))
      |-> (rsp_o.z_hi == '0 && rsp_o.z_lo == '0))

  `GCMGF_ASSERT(a_zero_y_gives_zero, clk_i, rst_ni,
    (done_o && $past(req_i.y_hi == '0 && req_i.y_lo == '0, gcmgf_pkg::Latency))
      |-> (rsp_o.z_hi == '0 && rsp_o.z_lo == '0))

  `GCMGF_ASSERT(a_one_y_gives_x, clk_i, rst_ni,
    (done_o && $past(req_i.y_hi == OneHi && req_i.y_lo == '0, gcmgf_pkg::Latency))
      |-> (rsp_o.z_hi == $past(req_i.x_hi, gcmgf_pkg::Latency) &&
           rsp_o.z_lo == $past(req_i.x_lo, gcmgf_pkg::Latency)))

endmodule

bind gcm_gf128_multiply_core gcmgf_checker u_gcmgf_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

// ===== bench/gcm_gf128_multiply_core_test.sv =====
// Self-checking bench for the GF(2^128) GHASH multiply core: random and corner-case
// operands are pushed through with random gaps, and each product is compared to a local model.
// Depends on gcmgf_pkg and gcm_gf128_multiply_core.
module gcm_gf128_multiply_core_test;

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned RandomItems   = 500;
  localparam int unsigned MaxGap        = 12;
  localparam int unsigned ReportLimit   = 10;
  // Cycles without any transfer before the run is declared hung; far above the
  // longest sender gap plus the pipeline depth.
  localparam int unsigned StallLimit    = 2000;
  localparam logic [127:0] ReductionPoly = {8'hE1, 120'h0};

  // Scoreboard: holds the products owed by the core, in input order.
  class gf_product_board;
    gcmgf_pkg::gcmgf_rsp_t pending_products[$];
    int unsigned           mismatches;

    // GCM bit order: bit 0 is the MSB of byte 0, so walk Y from its top bit,
    // add V into the sum, then shift V right and fold the dropped bit back in.
    function gcmgf_pkg::gcmgf_rsp_t gf_multiply(gcmgf_pkg::gcmgf_req_t op);
      logic [127:0]          v;
      logic [127:0]          y;
      logic [127:0]          acc;
      logic                  carry;
      gcmgf_pkg::gcmgf_rsp_t prod;
      v   = {op.x_hi, op.x_lo};
      y   = {op.y_hi, op.y_lo};
      acc = '0;
      for (int i = 0; i < 128; i++) begin
        if (y[127-i]) begin
          acc ^= v;
        end
        carry = v[0];
        v     = v >> 1;
        if (carry) begin
          v ^= ReductionPoly;
        end
      end
      prod.z_hi = acc[127:64];
      prod.z_lo = acc[63:0];
      return prod;
    endfunction

    function void note_operands(gcmgf_pkg::gcmgf_req_t op);
      pending_products.push_back(gf_multiply(op));
    endfunction

    function void check_product(gcmgf_pkg::gcmgf_rsp_t got);
      gcmgf_pkg::gcmgf_rsp_t want;
      if (pending_products.size() == 0) begin
        if (mismatches < ReportLimit) begin
          $display("unexpected product z_hi=%h z_lo=%h", got.z_hi, got.z_lo);
        end
        mismatches++;
        return;
      end
      want = pending_products.pop_front();
      if (got.z_hi !== want.z_hi || got.z_lo !== want.z_lo) begin
        if (mismatches < ReportLimit) begin
          $display("product mismatch: expected z_hi=%h z_lo=%h, got z_hi=%h z_lo=%h",
                   want.z_hi, want.z_lo, got.z_hi, got.z_lo);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  gcmgf_pkg::gcmgf_req_t req_i;
  logic                  done_o;
  gcmgf_pkg::gcmgf_rsp_t rsp_o;

  gf_product_board board;
  int unsigned     idle_cycles;
  int unsigned     burst_left;

  gcm_gf128_multiply_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Hold every input at a known value from time zero.
  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    idle_cycles = 0;
    burst_left  = 0;
    board       = new;
  end

  always #ClkHalf clk_i = ~clk_i;

  // Sample the result port mid-cycle: done_o and rsp_o only move at rising
  // edges, so the value seen here is the one the closing edge transfers.
  // The watchdog runs on the same sample point.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_product(rsp_o);
    end
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Draw a half-block, weighted toward zero, all-ones and single-bit values
  // so the reduction path and the field edges get hit often.
  function automatic logic [63:0] random_half();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return {64{1'b1}};
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic gcmgf_pkg::gcmgf_req_t make_op(logic [63:0] xh, logic [63:0] xl,
                                                    logic [63:0] yh, logic [63:0] yl);
    gcmgf_pkg::gcmgf_req_t op;
    op.x_hi = xh;
    op.x_lo = xl;
    op.y_hi = yh;
    op.y_lo = yl;
    return op;
  endfunction

  // Drive one operand pair. Pick the gap first: stretches of back-to-back
  // transfers alternate with random idles. Start stays high across a zero
  // gap, so it is never dropped and raised in the same step.
  task automatic send_operands(input gcmgf_pkg::gcmgf_req_t op);
    int unsigned gap;
    logic        taken;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MaxGap);
      if ($urandom_range(0, 15) == 0) begin
        burst_left = $urandom_range(4, 40);
      end
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= op;
    // Check busy mid-cycle; the next rising edge is the transfer if it is low.
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      if (taken) begin
        board.note_operands(op);
      end
      @(posedge clk_i);
    end while (!taken);
  endtask

  initial begin
    logic [63:0] ra;
    logic [63:0] rb;
    // Release reset once, after the hold time, on a rising edge.
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero operands, the field's one, all-ones and
    // single-bit values at both ends of each X half and of y_hi, and at the low end of y_lo.
    ra = {$urandom, $urandom};
    rb = {$urandom, $urandom};
    send_operands(make_op(64'h0, 64'h0, 64'h0, 64'h0));
    send_operands(make_op(64'h0, 64'h0, ra, rb));
    send_operands(make_op(ra, rb, 64'h0, 64'h0));
    send_operands(make_op(ra, rb, 64'h8000_0000_0000_0000, 64'h0));
    send_operands(make_op(64'h8000_0000_0000_0000, 64'h0, rb, ra));
    send_operands(make_op({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}));
    send_operands(make_op(64'h0, 64'h1, 64'h0, 64'h1));
    send_operands(make_op(64'h1, 64'h0, 64'h1, 64'h0));
    send_operands(make_op(64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h1));
    send_operands(make_op(64'h0, 64'h8000_0000_0000_0000,
                          64'h8000_0000_0000_0000, 64'h0));
    send_operands(make_op(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                          64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    send_operands(make_op({64{1'b1}}, {64{1'b1}}, 64'h0, 64'h1));
    send_operands(make_op(64'h0, 64'h1, {64{1'b1}}, {64{1'b1}}));
    send_operands(make_op(64'hE100_0000_0000_0000, 64'h0, ra, rb));

    // Random part; every 128-bit value is a valid field element.
    repeat (RandomItems) begin
      send_operands(make_op(random_half(), random_half(), random_half(), random_half()));
    end
    start_i <= 1'b0;

    // Drain: wait for every product owed, then wait longer than the pipeline
    // depth to catch any stray result.
    while (board.pending_products.size() != 0) @(posedge clk_i);
    repeat (gcmgf_pkg::Latency + 4) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending_products.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
